### rtl/core/tgac_pkg.sv
// Shared types and constants for the two-group absolute correlation unit.
// No dependencies. Used by the controller, datapath, top level and checker.
package tgac_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GSIZE_W    = 9;
    localparam int GCOUNT_W   = 16;
    localparam int POS_W      = 10;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 40;
    localparam int LEN_W      = 10;
    localparam int CORR_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_SAMPLES = 512;

    // back-end widths
    localparam int MUL_W   = 26;             // shared signed multiplier operand
    localparam int DD_W    = 52;             // n*Q - T*T, signed
    localparam int NUM_W   = 36;             // |n*S - d*T|
    localparam int SER_A_W = 72;             // shift-add multiplicand / accumulator
    localparam int REM_W   = 68;             // division remainder
    localparam int QUO_W   = 32;             // quotient bits
    localparam int ROOT_W  = 16;
    localparam int RREM_W  = 18;
    localparam int CNT_W   = 6;
    localparam int DIV_STEPS  = 32;
    localparam int ROOT_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GROUP_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_TWO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GENE_COUNT = 2'd2;

    typedef enum logic [4:0] {
        ST_ACC, ST_TT, ST_NQ_LD, ST_NQ_RUN, ST_DD, ST_CHK, ST_NS, ST_DT,
        ST_DIFF, ST_NN, ST_SQ_LD, ST_SQ_RUN, ST_SQ_SAVE, ST_B_LD, ST_B_RUN,
        ST_B_SAVE, ST_CMP, ST_DIV_LD, ST_DIV_RUN, ST_RT_LD, ST_RT_RUN,
        ST_RT_SAVE, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_TT, OP_SER_NQ, OP_SER_SQ, OP_SER_B, OP_SER_STEP, OP_DD,
        OP_DEG, OP_NS, OP_DT, OP_DIFF, OP_NN, OP_SAVE_SQ, OP_SAVE_B, OP_SAT,
        OP_DIV_LD, OP_DIV_STEP, OP_RT_LD, OP_RT_STEP, OP_ROOT, OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic   accept;     // take samples
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic gene_end;     // last sample of a gene taken this cycle
        logic ser_done;     // shift-add multiplier finished
        logic cnt_last;     // final divide / root step
        logic deg;          // variance term not positive
        logic sat;          // quotient reaches one
        logic out_free;     // output register can take a word
    } status_t;

endpackage

### rtl/core/tgac_ctrl.sv
// Sequencer for the two-group absolute correlation unit.
// Depends on tgac_pkg; drives tgac_dp through cmd_t and reads status_t.
module tgac_ctrl
    import tgac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:     if (status.gene_end) state_next = ST_TT;
            ST_TT:      state_next = ST_NQ_LD;
            ST_NQ_LD:   state_next = ST_NQ_RUN;
            ST_NQ_RUN:  if (status.ser_done) state_next = ST_DD;
            ST_DD:      state_next = ST_CHK;
            ST_CHK:     state_next = status.deg ? ST_OUT : ST_NS;
            ST_NS:      state_next = ST_DT;
            ST_DT:      state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_NN;
            ST_NN:      state_next = ST_SQ_LD;
            ST_SQ_LD:   state_next = ST_SQ_RUN;
            ST_SQ_RUN:  if (status.ser_done) state_next = ST_SQ_SAVE;
            ST_SQ_SAVE: state_next = ST_B_LD;
            ST_B_LD:    state_next = ST_B_RUN;
            ST_B_RUN:   if (status.ser_done) state_next = ST_B_SAVE;
            ST_B_SAVE:  state_next = ST_CMP;
            ST_CMP:     state_next = status.sat ? ST_OUT : ST_DIV_LD;
            ST_DIV_LD:  state_next = ST_DIV_RUN;
            ST_DIV_RUN: if (status.cnt_last) state_next = ST_RT_LD;
            ST_RT_LD:   state_next = ST_RT_RUN;
            ST_RT_RUN:  if (status.cnt_last) state_next = ST_RT_SAVE;
            ST_RT_SAVE: state_next = ST_OUT;
            ST_OUT:     if (status.out_free) state_next = ST_ACC;
            default:    state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_ACC:     cmd.accept = 1'b1;
            ST_TT:      cmd.op = OP_TT;
            ST_NQ_LD:   cmd.op = OP_SER_NQ;
            ST_NQ_RUN:  cmd.op = OP_SER_STEP;
            ST_DD:      cmd.op = OP_DD;
            ST_CHK:     cmd.op = status.deg ? OP_DEG : OP_NONE;
            ST_NS:      cmd.op = OP_NS;
            ST_DT:      cmd.op = OP_DT;
            ST_DIFF:    cmd.op = OP_DIFF;
            ST_NN:      cmd.op = OP_NN;
            ST_SQ_LD:   cmd.op = OP_SER_SQ;
            ST_SQ_RUN:  cmd.op = OP_SER_STEP;
            ST_SQ_SAVE: cmd.op = OP_SAVE_SQ;
            ST_B_LD:    cmd.op = OP_SER_B;
            ST_B_RUN:   cmd.op = OP_SER_STEP;
            ST_B_SAVE:  cmd.op = OP_SAVE_B;
            ST_CMP:     cmd.op = status.sat ? OP_SAT : OP_NONE;
            ST_DIV_LD:  cmd.op = OP_DIV_LD;
            ST_DIV_RUN: cmd.op = OP_DIV_STEP;
            ST_RT_LD:   cmd.op = OP_RT_LD;
            ST_RT_RUN:  cmd.op = OP_RT_STEP;
            ST_RT_SAVE: cmd.op = OP_ROOT;
            ST_OUT:     cmd.op = status.out_free ? OP_OUT : OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/core/tgac_dp.sv
// Datapath: configuration registers, per-gene accumulators and the
// once-per-gene back end (multiplier, shift-add unit, divider, root). Uses tgac_pkg.
module tgac_dp
    import tgac_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    input  logic signed [SAMPLE_W-1:0]   sample_value,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [CORR_W-1:0]            correlation,
    output logic [GCOUNT_W-1:0]          gene_index,
    output logic                         degenerate,
    output logic                         last_gene
);

    // configuration
    logic [GSIZE_W-1:0]  g1_reg;
    logic [GSIZE_W-1:0]  g2_reg;
    logic [GCOUNT_W-1:0] gcount_reg;

    // accumulation
    logic [POS_W-1:0]    pos_reg;
    logic [GCOUNT_W-1:0] gpos_reg;
    logic [SUM_W-1:0]    plain_reg;
    logic [SUM_W-1:0]    lsum_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic                out_valid_reg;

    logic [POS_W-1:0]    pos_next;
    logic [SUM_W-1:0]    plain_next;
    logic [SUM_W-1:0]    lsum_next;
    logic [SQ_W-1:0]     sq_next;
    logic [SUM_W-1:0]    x_ext;
    logic signed [2*SAMPLE_W-1:0] x_wide;
    logic [2*SAMPLE_W-1:0] x_sq;
    logic [LEN_W-1:0]    n_cur;
    logic [LEN_W:0]      len_sum;
    logic [LEN_W-1:0]    g1_min;
    logic signed [LEN_W:0] d_cur;
    logic                in_fire;
    logic                gene_end;
    logic                is_last;

    // gene snapshot
    logic signed [SUM_W-1:0] t_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic [SQ_W-1:0]         q_reg;
    logic [LEN_W-1:0]        n_reg;
    logic signed [LEN_W:0]   d_reg;
    logic [GCOUNT_W-1:0]     idx_reg;
    logic                    last_reg;

    // back end
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [DD_W-1:0]    tt_reg;
    logic signed [DD_W-1:0]    dd_reg;
    logic signed [NUM_W-1:0]   ns_reg;
    logic signed [NUM_W:0]     dt_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [LEN_W*2-2:0]        nn_reg;
    logic [SER_A_W-1:0]        ser_a_reg;
    logic [NUM_W-1:0]          ser_b_reg;
    logic [SER_A_W-1:0]        acc_reg;
    logic [SER_A_W-1:0]        num2_reg;
    logic [SER_A_W-1:0]        bden_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic [QUO_W-1:0]          src_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [RREM_W-1:0]         rrem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CORR_W-1:0]         res_reg;
    logic                      deg_reg;

    logic signed [DD_W-1:0]    dd_next;
    logic signed [NUM_W+1:0]   diff;
    logic [NUM_W+1:0]          diff_abs;
    logic [SER_A_W-1:0]        div_sh;
    logic [RREM_W+1:0]         rt_sh;
    logic [RREM_W+1:0]         rt_trial;

    logic [CORR_W-1:0]         corr_out_reg;
    logic [GCOUNT_W-1:0]       gidx_out_reg;
    logic                      deg_out_reg;
    logic                      last_out_reg;

    // gene length and label balance from the current configuration
    always_comb
    begin
        len_sum = {1'b0, g1_reg} + {1'b0, g2_reg};
        if (len_sum > (LEN_W+1)'(MAX_SAMPLES))
            n_cur = LEN_W'(MAX_SAMPLES);
        else if (len_sum == '0)
            n_cur = LEN_W'(1);
        else
            n_cur = len_sum[LEN_W-1:0];
        g1_min = ({1'b0, g1_reg} < n_cur) ? {1'b0, g1_reg} : n_cur;
        d_cur  = $signed({1'b0, n_cur}) - $signed({g1_min, 1'b0});
    end

    assign in_fire  = in_valid & cmd.accept;
    assign x_ext    = {{(SUM_W-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
    assign x_wide   = {{SAMPLE_W{sample_value[SAMPLE_W-1]}}, sample_value};
    assign x_sq     = x_wide * x_wide;
    assign pos_next = pos_reg + POS_W'(1);
    assign plain_next = plain_reg + x_ext;
    assign lsum_next  = ({1'b0, pos_reg} < {2'b00, g1_reg}) ? lsum_reg - x_ext
                                                             : lsum_reg + x_ext;
    assign sq_next  = sq_reg + SQ_W'(x_sq);
    assign gene_end = (pos_next >= n_cur) || (pos_next == '0);
    assign is_last  = (gpos_reg == (gcount_reg - GCOUNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_reg        <= GSIZE_W'(1);
            g2_reg        <= GSIZE_W'(1);
            gcount_reg    <= GCOUNT_W'(1);
            pos_reg       <= '0;
            gpos_reg      <= '0;
            plain_reg     <= '0;
            lsum_reg      <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_GROUP_ONE:  g1_reg     <= cfg_data[GSIZE_W-1:0];
                    REG_GROUP_TWO:  g2_reg     <= cfg_data[GSIZE_W-1:0];
                    REG_GENE_COUNT: gcount_reg <= cfg_data[GCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                if (gene_end)
                begin
                    pos_reg   <= '0;
                    plain_reg <= '0;
                    lsum_reg  <= '0;
                    sq_reg    <= '0;
                    gpos_reg  <= is_last ? '0 : gpos_reg + GCOUNT_W'(1);
                end
                else
                begin
                    pos_reg   <= pos_next;
                    plain_reg <= plain_next;
                    lsum_reg  <= lsum_next;
                    sq_reg    <= sq_next;
                end
            end
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // shared signed multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_TT:
            begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            OP_NS:
            begin
                mul_a = $signed(MUL_W'(n_reg));
                mul_b = s_reg;
            end
            OP_DT:
            begin
                mul_a = {{(MUL_W-LEN_W-1){d_reg[LEN_W]}}, d_reg};
                mul_b = t_reg;
            end
            OP_NN:
            begin
                mul_a = $signed(MUL_W'(n_reg));
                mul_b = $signed(MUL_W'(n_reg));
            end
            default: ;
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign dd_next  = $signed({2'b00, acc_reg[DD_W-3:0]}) - tt_reg;
    assign diff     = $signed({{2{ns_reg[NUM_W-1]}}, ns_reg}) - $signed({dt_reg[NUM_W], dt_reg});
    assign diff_abs = diff[NUM_W+1] ? $unsigned(-diff) : $unsigned(diff);
    assign div_sh   = {{(SER_A_W-REM_W-1){1'b0}}, rem_reg, 1'b0};
    assign rt_sh    = {rrem_reg, src_reg[QUO_W-1 -: 2]};
    assign rt_trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk)
    begin
        if (in_fire && gene_end)
        begin
            t_reg    <= plain_next;
            s_reg    <= lsum_next;
            q_reg    <= sq_next;
            n_reg    <= n_cur;
            d_reg    <= d_cur;
            idx_reg  <= gpos_reg;
            last_reg <= is_last;
        end
        unique case (cmd.op)
            OP_TT:   tt_reg <= mul_p;
            OP_DD:   dd_reg <= dd_next;
            OP_NS:   ns_reg <= mul_p[NUM_W-1:0];
            OP_DT:   dt_reg <= mul_p[NUM_W:0];
            OP_DIFF: num_reg <= diff_abs[NUM_W-1:0];
            OP_NN:   nn_reg <= mul_p[LEN_W*2-2:0];
            OP_SER_NQ:
            begin
                ser_a_reg <= SER_A_W'(q_reg);
                ser_b_reg <= NUM_W'(n_reg);
                acc_reg   <= '0;
            end
            OP_SER_SQ:
            begin
                ser_a_reg <= SER_A_W'(num_reg);
                ser_b_reg <= num_reg;
                acc_reg   <= '0;
            end
            OP_SER_B:
            begin
                ser_a_reg <= SER_A_W'(dd_reg[DD_W-4:0]);
                ser_b_reg <= NUM_W'(nn_reg);
                acc_reg   <= '0;
            end
            OP_SER_STEP:
            begin
                if (ser_b_reg[0])
                    acc_reg <= acc_reg + ser_a_reg;
                ser_a_reg <= ser_a_reg << 1;
                ser_b_reg <= ser_b_reg >> 1;
            end
            OP_SAVE_SQ: num2_reg <= acc_reg;
            OP_SAVE_B:  bden_reg <= acc_reg;
            OP_DIV_LD:
            begin
                rem_reg <= num2_reg[REM_W-1:0];
                quo_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            OP_DIV_STEP:
            begin
                if (div_sh >= bden_reg)
                begin
                    rem_reg <= REM_W'(div_sh - bden_reg);
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_sh[REM_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_RT_LD:
            begin
                src_reg  <= quo_reg;
                root_reg <= '0;
                rrem_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_STEPS);
            end
            OP_RT_STEP:
            begin
                if (rt_sh >= rt_trial)
                begin
                    rrem_reg <= RREM_W'(rt_sh - rt_trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= rt_sh[RREM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                src_reg <= src_reg << 2;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_DEG:
            begin
                res_reg <= '0;
                deg_reg <= 1'b1;
            end
            OP_SAT:
            begin
                res_reg <= CORR_W'(1) << ROOT_W;
                deg_reg <= 1'b0;
            end
            OP_ROOT:
            begin
                res_reg <= CORR_W'(root_reg);
                deg_reg <= 1'b0;
            end
            OP_OUT:
            begin
                corr_out_reg <= res_reg;
                gidx_out_reg <= idx_reg;
                deg_out_reg  <= deg_reg;
                last_out_reg <= last_reg;
            end
            default: ;
        endcase
    end

    assign status.gene_end = in_fire & gene_end;
    assign status.ser_done = (ser_b_reg == '0);
    assign status.cnt_last = (cnt_reg == CNT_W'(1));
    assign status.deg      = dd_reg[DD_W-1] || (dd_reg == '0);
    assign status.sat      = (num2_reg >= bden_reg);
    assign status.out_free = ~out_valid_reg | out_ready;

    assign out_valid   = out_valid_reg;
    assign correlation = corr_out_reg;
    assign gene_index  = gidx_out_reg;
    assign degenerate  = deg_out_reg;
    assign last_gene   = last_out_reg;

endmodule

### rtl/core/two_group_abs_correlation_unit.sv
// Top level of the two-group absolute correlation unit.
// Depends on tgac_pkg, tgac_ctrl and tgac_dp.
//
// Samples stream in on the sample word channel, genes back to back; the first
// group_one_size samples of a gene count as label -1, the rest as +1, and a gene is
// group_one_size + group_two_size samples long (at most 512). Samples are taken one
// per cycle into the running sums while in_ready is high. The last sample of a gene
// starts the back end, which computes floor(65536 * |nS - dT| / (n * sqrt(nQ - T^2))),
// capped at 65536, exactly in integers; while it runs, in_ready is low. The back end
// is one shared 26x26 multiplier, a 1-bit-per-cycle shift-add multiplier, a 32-step
// restoring divider and a 16-step square root. A degenerate gene (all samples equal)
// ends after the variance check and reports 0 with the degenerate flag, and a ratio
// of one or more skips the divide and root. Results sit in an output register, so the
// next gene's samples are taken while a result word waits for out_ready. Configuration
// writes are taken on any cycle (cfg_ready is always high) and must only be issued
// while the unit is idle.
module two_group_abs_correlation_unit
    import tgac_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CORR_W-1:0]           correlation,
    output logic [GCOUNT_W-1:0]         gene_index,
    output logic                        degenerate,
    output logic                        last_gene
);

    cmd_t    cmd;
    status_t status;

    // hold the sample channel while the back end works on a gene
    assign in_ready  = cmd.accept;
    assign cfg_ready = 1'b1;

    tgac_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tgac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .sample_value (sample_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .correlation  (correlation),
        .gene_index   (gene_index),
        .degenerate   (degenerate),
        .last_gene    (last_gene)
    );

endmodule

### rtl/core/tgac_checker.sv
// Port-level checks for two_group_abs_correlation_unit, bound to the top level.
// Depends on tgac_pkg.
module tgac_checker
    import tgac_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [CORR_W-1:0]   correlation,
    input logic                degenerate
);

    localparam logic [CORR_W-1:0] CORR_ONE = CORR_W'(1) << ROOT_W;

    a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (correlation <= CORR_ONE))
        else $error("correlation above one");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (correlation == '0))
        else $error("degenerate word with nonzero correlation");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(correlation)))
        else $error("result word dropped or changed while stalled");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel blocked");

endmodule

bind two_group_abs_correlation_unit tgac_checker u_tgac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .correlation (correlation),
    .degenerate  (degenerate)
);

### bench/two_group_abs_correlation_unit_tb.sv
// Self-checking bench for two_group_abs_correlation_unit: streams signed sample words,
// predicts each gene's correlation word exactly in integers, and compares field by field.
// Depends on tgac_pkg and the unit's RTL.
module two_group_abs_correlation_unit_tb
    import tgac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CORR_W-1:0]   corr;
        logic [GCOUNT_W-1:0] idx;
        logic                deg;
        logic                last;
    } gene_result_t;

    // Scoreboard: running sums of the current gene and the queue of pending gene results.
    class corr_board;
        logic [GSIZE_W-1:0]  grp_one = 1;
        logic [GSIZE_W-1:0]  grp_two = 1;
        logic [GCOUNT_W-1:0] genes_per_set = 1;
        logic [POS_W-1:0]    pos = 0;
        logic [GCOUNT_W-1:0] gene_pos = 0;
        logic [SUM_W-1:0]    total = 0;
        logic [SUM_W-1:0]    signed_total = 0;
        logic [SQ_W-1:0]     squares = 0;
        gene_result_t        pending[$];
        int                  mismatches = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_GROUP_ONE) grp_one = data[GSIZE_W-1:0];
            else if (idx == REG_GROUP_TWO) grp_two = data[GSIZE_W-1:0];
            else if (idx == REG_GENE_COUNT) genes_per_set = data;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            longint       xv, n, g1, d, t, s, dd, diff;
            logic [127:0] rhs, prod, kk;
            logic [16:0]  r, c;
            gene_result_t res;
            xv = x;
            n = longint'(grp_one) + longint'(grp_two);
            if (n > MAX_SAMPLES) n = MAX_SAMPLES;
            if (n == 0) n = 1;
            g1 = (grp_one < n) ? grp_one : n;
            total += SUM_W'(xv);
            if (pos < grp_one) signed_total -= SUM_W'(xv);
            else signed_total += SUM_W'(xv);
            squares += SQ_W'(xv * xv);
            pos++;
            if (pos < n && pos != 0) return;
            d = n - 2 * g1;
            t = longint'(signed'(total));
            s = longint'(signed'(signed_total));
            dd = n * longint'(squares) - t * t;
            res.idx = gene_pos;
            res.last = (gene_pos == GCOUNT_W'(genes_per_set - 1));
            if (dd <= 0) begin
                res.corr = '0;
                res.deg = 1'b1;
            end
            else begin
                diff = n * s - d * t;
                if (diff < 0) diff = -diff;
                rhs = (128'(diff) * 128'(diff)) << 32;
                r = 0;
                // bitwise search for the largest r with (r*n)^2 * dd <= num^2 * 2^32
                for (int b = 16; b >= 0; b--) begin
                    c = r | (17'd1 << b);
                    if (c <= 17'd65536) begin
                        kk = 128'(c) * 128'(c) * 128'(n) * 128'(n);
                        prod = kk * 128'(dd);
                        if (prod <= rhs) r = c;
                    end
                end
                res.corr = r;
                res.deg = 1'b0;
            end
            pending.push_back(res);
            pos = 0;
            total = 0;
            signed_total = 0;
            squares = 0;
            gene_pos = res.last ? '0 : gene_pos + 1'b1;
        endfunction

        function void check_result(gene_result_t got);
            gene_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word corr=%0d idx=%0d deg=%0b last=%0b",
                             got.corr, got.idx, got.deg, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.corr !== want.corr || got.idx !== want.idx ||
                got.deg !== want.deg || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: gene %0d expected corr=%0d idx=%0d deg=%0b last=%0b,",
                              " got corr=%0d idx=%0d deg=%0b last=%0b"},
                             want.idx, want.corr, want.idx, want.deg, want.last,
                             got.corr, got.idx, got.deg, got.last);
            end
        endfunction
    endclass

    typedef enum int {PAT_WIDE, PAT_NARROW, PAT_ALIGNED, PAT_FLAT, PAT_EDGES} pattern_t;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  sample_value;
    logic                        out_valid;
    logic                        out_ready;
    logic [CORR_W-1:0]           correlation;
    logic [GCOUNT_W-1:0]         gene_index;
    logic                        degenerate;
    logic                        last_gene;

    corr_board board = new();
    int        send_idle_pct = 0;   // chance the sender skips a cycle
    int        recv_stall_pct = 0;  // chance the receiver drops out_ready
    bit        hold_off = 0;        // long receiver hold-off, driven by its own process
    int        samples_sent = 0;
    longint    cycles = 0;

    two_group_abs_correlation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .sample_value(sample_value),
        .out_valid(out_valid), .out_ready(out_ready), .correlation(correlation),
        .gene_index(gene_index), .degenerate(degenerate), .last_gene(last_gene)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: count cycles and give up at the limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off entirely while hold_off is set.
    always @(negedge clk) begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every result word taken at a rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result({correlation, gene_index, degenerate, last_gene});
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sample word until accepted; leave the bench at the next falling edge.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample_value = x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_sample(x);
        samples_sent++;
        @(negedge clk);
    endtask

    // Wait until every expected word has come, then let the back end settle.
    task automatic drain();
        in_valid = 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic configure(int g1, int g2, int count);
        write_cfg(REG_GROUP_ONE, CFG_DATA_W'(g1));
        write_cfg(REG_GROUP_TWO, CFG_DATA_W'(g2));
        write_cfg(REG_GENE_COUNT, CFG_DATA_W'(count));
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(pattern_t pat, int p,
                                                                int level, int g1);
        int a;
        case (pat)
            PAT_NARROW:  return SAMPLE_W'($urandom_range(3) - 1);
            PAT_ALIGNED: begin
                a = level + $urandom_range(2);
                return SAMPLE_W'((p < g1) ? -a : a);
            end
            PAT_FLAT:    return SAMPLE_W'(level);
            PAT_EDGES:   return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default:     return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Send whole genes of the current length with one pattern per gene.
    task automatic run_genes(int genes, int g1, int g2);
        int       n, level;
        pattern_t pat;
        n = g1 + g2;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        for (int g = 0; g < genes; g++) begin
            pat = pattern_t'($urandom_range(4));
            level = $urandom_range(1) ? int'($urandom_range(1000)) : int'($urandom) - 32768;
            if (pat == PAT_ALIGNED && level > 32000) level = 32000;
            if (pat == PAT_ALIGNED && level < 0) level = -level;
            for (int p = 0; p < n; p++)
                send_sample(pick_sample(pat, p, level, g1));
        end
    endtask

    initial begin
        int g1, g2, count, phase;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_value = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full-scale samples, perfect and anti-aligned pairs, a flat gene.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd5);
        send_sample(16'sd5);
        drain();
        // Three-gene set with unequal groups; flat gene at the negative extreme.
        configure(2, 3, 3);
        for (int p = 0; p < 5; p++) send_sample(16'sh8000);
        for (int p = 0; p < 5; p++) send_sample((p < 2) ? -16'sd7 : 16'sd9);
        for (int p = 0; p < 5; p++) send_sample(SAMPLE_W'($urandom));
        drain();
        // Largest groups: the gene length clamps to its maximum.
        configure(511, 511, 1);
        run_genes(1, 511, 511);
        drain();
        // Gene count far above the genes sent: index keeps counting across phases.
        configure(1, 511, 65535);
        run_genes(1, 1, 511);
        drain();

        // Random phases, cycling through the idling modes; mostly short genes.
        phase = 0;
        while (samples_sent < 1800 || phase < 4) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if ($urandom_range(9) == 0) begin
                g1 = $urandom_range(511, 1);
                g2 = $urandom_range(511, 1);
            end
            else if ($urandom_range(4) == 0) begin
                g1 = $urandom_range(40, 1);
                g2 = $urandom_range(40, 1);
            end
            else begin
                g1 = $urandom_range(6, 1);
                g2 = $urandom_range(6, 1);
            end
            count = ($urandom_range(9) == 0) ? 65535 : int'($urandom_range(6, 1));
            configure(g1, g2, count);
            // Once, hold the receiver off long enough to back the unit up.
            if (phase == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (2000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            run_genes((g1 + g2 > 100) ? 1 : int'($urandom_range(12, 2)), g1, g2);
            drain();
            phase++;
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
